FILE: hw/rtl/cc20_pkg.sv
// Package: shared types, constants and helpers for the ChaCha20 random word generator.
package cc20_pkg;

    localparam logic [31:0] C_SIGMA0 = 32'h61707865;
    localparam logic [31:0] C_SIGMA1 = 32'h3320646e;
    localparam logic [31:0] C_SIGMA2 = 32'h79622d32;
    localparam logic [31:0] C_SIGMA3 = 32'h6b206574;

    localparam int unsigned NumWords  = 16;
    localparam int unsigned NumDouble = 10;

    typedef enum logic [1:0] {
        FUNC_WORD    = 2'd0,
        FUNC_UNIFORM = 2'd1,
        FUNC_BYTE    = 2'd2,
        FUNC_NONE    = 2'd3
    } t_func;

    localparam logic [2:0] REG_KEY01 = 3'd0;
    localparam logic [2:0] REG_KEY23 = 3'd1;
    localparam logic [2:0] REG_KEY45 = 3'd2;
    localparam logic [2:0] REG_KEY67 = 3'd3;
    localparam logic [2:0] REG_NONCE = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD_MIN,
        ST_BYTE,
        ST_BLK_START,
        ST_BLK_WAIT,
        ST_CHECK,
        ST_MOD_RES,
        ST_DONE
    } t_state;

    // status from block core to top
    typedef struct packed {
        logic busy;
        logic done;
    } t_blk_status;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        rotl = (x << n) | (x >> (6'd32 - {1'b0, n}));
    endfunction

endpackage

FILE: hw/rtl/cc20_core.sv
// ChaCha20 block function: one quarter round per cycle on a shared quarter-round unit.
module cc20_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [511:0]         i_block_in,
    output logic [31:0]          o_words [cc20_pkg::NumWords],
    output cc20_pkg::t_blk_status o_status
);

    logic [31:0] r_x [cc20_pkg::NumWords];
    logic [31:0] r_in [cc20_pkg::NumWords];
    logic [2:0]  r_qr;
    logic [3:0]  r_dr;
    logic        r_busy;
    logic        r_done;
    logic        r_fin;

    logic [3:0] s_a, s_b, s_c, s_d;
    logic [31:0] s_a0, s_b0, s_c0, s_d0;
    logic [31:0] s_a1, s_b1, s_c1, s_d1, s_a2, s_b2, s_c2, s_d2;

    always_comb begin
        case (r_qr)
            3'd0: begin s_a = 4'd0; s_b = 4'd4; s_c = 4'd8;  s_d = 4'd12; end
            3'd1: begin s_a = 4'd1; s_b = 4'd5; s_c = 4'd9;  s_d = 4'd13; end
            3'd2: begin s_a = 4'd2; s_b = 4'd6; s_c = 4'd10; s_d = 4'd14; end
            3'd3: begin s_a = 4'd3; s_b = 4'd7; s_c = 4'd11; s_d = 4'd15; end
            3'd4: begin s_a = 4'd0; s_b = 4'd5; s_c = 4'd10; s_d = 4'd15; end
            3'd5: begin s_a = 4'd1; s_b = 4'd6; s_c = 4'd11; s_d = 4'd12; end
            3'd6: begin s_a = 4'd2; s_b = 4'd7; s_c = 4'd8;  s_d = 4'd13; end
            default: begin s_a = 4'd3; s_b = 4'd4; s_c = 4'd9; s_d = 4'd14; end
        endcase
    end

    always_comb begin
        s_a0 = r_x[s_a];
        s_b0 = r_x[s_b];
        s_c0 = r_x[s_c];
        s_d0 = r_x[s_d];
        s_a1 = s_a0 + s_b0;
        s_d1 = cc20_pkg::rotl(s_d0 ^ s_a1, 5'd16);
        s_c1 = s_c0 + s_d1;
        s_b1 = cc20_pkg::rotl(s_b0 ^ s_c1, 5'd12);
        s_a2 = s_a1 + s_b1;
        s_d2 = cc20_pkg::rotl(s_d1 ^ s_a2, 5'd8);
        s_c2 = s_c1 + s_d2;
        s_b2 = cc20_pkg::rotl(s_b1 ^ s_c2, 5'd7);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            r_qr   <= '0;
            r_dr   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_fin  <= 1'b0;
                r_qr   <= '0;
                r_dr   <= '0;
            end else if (r_busy && r_fin) begin
                r_busy <= 1'b0;
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end else if (r_busy) begin
                r_qr <= r_qr + 3'd1;
                if (r_qr == 3'd7) begin
                    r_dr <= r_dr + 4'd1;
                    if (r_dr == 4'(cc20_pkg::NumDouble - 1)) begin
                        r_fin <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            for (int i = 0; i < cc20_pkg::NumWords; i++) begin
                r_x[i]  <= i_block_in[32*i +: 32];
                r_in[i] <= i_block_in[32*i +: 32];
            end
        end else if (r_busy && r_fin) begin
            for (int i = 0; i < cc20_pkg::NumWords; i++) begin
                r_x[i] <= r_x[i] + r_in[i];
            end
        end else if (r_busy) begin
            r_x[s_a] <= s_a2;
            r_x[s_b] <= s_b2;
            r_x[s_c] <= s_c2;
            r_x[s_d] <= s_d2;
        end
    end

    assign o_words = r_x;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

`ifndef NO_ASSERTIONS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.done |-> $past(r_busy)) else $error("done without busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.done |=> !o_status.done) else $error("done held");
    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> r_busy) else $error("finish while idle");
`endif

endmodule

FILE: hw/rtl/cc20_divu.sv
// Restoring 32-bit unsigned remainder, one quotient bit per cycle.
module cc20_divu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic [31:0] o_rem,
    output logic        o_done
);

    logic [31:0] r_num;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] s_sh;
    logic [33:0] s_diff;

    assign s_sh   = {r_rem[31:0], r_num[31]};
    assign s_diff = {1'b0, s_sh} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_num <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[30:0], 1'b0};
            r_rem <= s_diff[33] ? s_sh : s_diff[32:0];
        end
    end

    assign o_rem  = r_rem[31:0];
    assign o_done = r_done;

`ifndef NO_ASSERTIONS
    a_rem_lt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_den != 32'd0) |-> (r_rem[31:0] < r_den)) else $error("rem too big");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held");
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy)) else $error("done without busy");
`endif

endmodule

FILE: hw/rtl/chacha20_random_word_generator.sv
// Top level: ChaCha20 keystream random source with APB configuration and stream ports.
// Each request runs from acceptance to its result through a byte sequencer, one keystream
// byte per step (one for a byte, four for a word), then a check and a hand-off state.
// Whenever the 64-byte buffer runs empty, a block is computed on a single shared
// quarter-round unit, 80 quarter rounds plus start, add-back and handshake.
// Uniform mode adds a serial remainder for the rejection threshold and another per
// accepted draw, plus one word per rejected draw. Bounds below two and code three go
// from acceptance straight to the hand-off state. The next request is taken in the cycle
// after the result has left m_tdata.
module chacha20_random_word_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [1:0] func, [33:2] limit, [39:34] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] random_value
);

    logic [63:0] r_cfg [5];
    logic [63:0] r_ctr;
    logic [6:0]  r_left;
    logic [31:0] r_ks [cc20_pkg::NumWords];
    cc20_pkg::t_state r_st, n_st;
    logic [1:0]  r_func;
    logic [31:0] r_bound;
    logic [31:0] r_min;
    logic [31:0] r_acc;
    logic [1:0]  r_bcnt;
    logic [1:0]  r_need;
    logic [31:0] r_out;
    logic        r_mvalid;
    logic        r_wantmin;

    logic [2:0]  s_idx;
    logic [5:0]  s_pos;
    logic [31:0] s_w;
    logic [7:0]  s_byte;
    logic        s_wr;
    logic        s_blk_start;
    logic        s_div_start;
    logic [31:0] s_div_a;
    logic [511:0] s_blk_in;
    logic [31:0] s_words [cc20_pkg::NumWords];
    cc20_pkg::t_blk_status s_bst;
    logic [31:0] s_rem;
    logic        s_div_done;
    logic        s_acc_full;

    assign pready = 1'b1;
    assign s_idx  = paddr[5:3];
    assign s_wr   = psel && penable && pwrite;
    always_comb begin
        prdata = '0;
        if (s_idx <= cc20_pkg::REG_NONCE) begin
            prdata = r_cfg[s_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) begin
                r_cfg[i] <= '0;
            end
        end else if (s_wr && s_idx <= cc20_pkg::REG_NONCE) begin
            r_cfg[s_idx] <= pwdata;
        end
    end

    assign s_blk_in = {r_cfg[cc20_pkg::REG_NONCE], r_ctr,
                       r_cfg[cc20_pkg::REG_KEY67], r_cfg[cc20_pkg::REG_KEY45],
                       r_cfg[cc20_pkg::REG_KEY23], r_cfg[cc20_pkg::REG_KEY01],
                       cc20_pkg::C_SIGMA3, cc20_pkg::C_SIGMA2,
                       cc20_pkg::C_SIGMA1, cc20_pkg::C_SIGMA0};

    cc20_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_blk_start),
        .i_block_in (s_blk_in),
        .o_words    (s_words),
        .o_status   (s_bst)
    );

    cc20_divu u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_div_start),
        .i_dividend (s_div_a),
        .i_divisor  (r_bound),
        .o_rem      (s_rem),
        .o_done     (s_div_done)
    );

    assign s_pos  = 6'(7'd64 - r_left);
    assign s_w    = r_ks[s_pos[5:2]];
    assign s_byte = s_w[8*s_pos[1:0] +: 8];
    assign s_acc_full = (r_bcnt == r_need);
    assign s_div_a = r_wantmin ? (32'd0 - r_bound) : r_acc;

    always_comb begin
        n_st = r_st;
        case (r_st)
            cc20_pkg::ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    if (s_tdata[1:0] == cc20_pkg::FUNC_NONE ||
                        (s_tdata[1:0] == cc20_pkg::FUNC_UNIFORM && s_tdata[33:3] == '0)) begin
                        n_st = cc20_pkg::ST_DONE;
                    end else if (s_tdata[1:0] == cc20_pkg::FUNC_UNIFORM) begin
                        n_st = cc20_pkg::ST_MOD_MIN;
                    end else begin
                        n_st = cc20_pkg::ST_BYTE;
                    end
                end
            end
            cc20_pkg::ST_MOD_MIN: if (s_div_done) n_st = cc20_pkg::ST_BYTE;
            cc20_pkg::ST_BYTE: begin
                if (r_left == 7'd0 || r_left > 7'd64) n_st = cc20_pkg::ST_BLK_START;
                else if (s_acc_full) n_st = cc20_pkg::ST_CHECK;
            end
            cc20_pkg::ST_BLK_START: n_st = cc20_pkg::ST_BLK_WAIT;
            cc20_pkg::ST_BLK_WAIT: if (s_bst.done) n_st = cc20_pkg::ST_BYTE;
            cc20_pkg::ST_CHECK: begin
                if (r_func != cc20_pkg::FUNC_UNIFORM) n_st = cc20_pkg::ST_DONE;
                else if (r_acc < r_min) n_st = cc20_pkg::ST_BYTE;
                else n_st = cc20_pkg::ST_MOD_RES;
            end
            cc20_pkg::ST_MOD_RES: if (s_div_done) n_st = cc20_pkg::ST_DONE;
            cc20_pkg::ST_DONE: if (!r_mvalid || m_tready) n_st = cc20_pkg::ST_IDLE;
            default: n_st = cc20_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        s_blk_start = 1'b0;
        s_div_start = 1'b0;
        case (r_st)
            cc20_pkg::ST_IDLE:      s_tready = !r_mvalid;
            cc20_pkg::ST_MOD_MIN:   s_div_start = !s_div_done;
            cc20_pkg::ST_BLK_START: s_blk_start = 1'b1;
            cc20_pkg::ST_MOD_RES:   s_div_start = !s_div_done;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= cc20_pkg::ST_IDLE;
            r_ctr    <= '0;
            r_left   <= '0;
            r_mvalid <= 1'b0;
            r_bcnt   <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == cc20_pkg::ST_DONE && (!r_mvalid || m_tready)) begin
                r_mvalid <= 1'b1;
            end else if (m_tvalid && m_tready) begin
                r_mvalid <= 1'b0;
            end
            case (r_st)
                cc20_pkg::ST_IDLE: r_bcnt <= '0;
                cc20_pkg::ST_BYTE: begin
                    if (!(r_left == 7'd0 || r_left > 7'd64)) begin
                        r_left <= r_left - 7'd1;
                        if (!s_acc_full) r_bcnt <= r_bcnt + 2'd1;
                    end
                end
                cc20_pkg::ST_BLK_WAIT: begin
                    if (s_bst.done) begin
                        r_left <= 7'd64;
                        r_ctr  <= r_ctr + 64'd1;
                    end
                end
                cc20_pkg::ST_CHECK: r_bcnt <= '0;
                default: ;
            endcase
        end
    end

    // s_acc_full tests one step early: r_need is last byte index
    always_ff @(posedge i_clk) begin
        case (r_st)
            cc20_pkg::ST_IDLE: begin
                r_func    <= s_tdata[1:0];
                r_bound   <= s_tdata[33:2];
                r_need    <= (s_tdata[1:0] == cc20_pkg::FUNC_BYTE) ? 2'd0 : 2'd3;
                r_acc     <= '0;
                r_wantmin <= 1'b1;
                r_min     <= '0;
                if (s_tvalid && s_tready) r_out <= '0;
            end
            cc20_pkg::ST_MOD_MIN: if (s_div_done) begin
                r_min     <= s_rem;
                r_wantmin <= 1'b0;
            end
            cc20_pkg::ST_BYTE: begin
                if (!(r_left == 7'd0 || r_left > 7'd64)) begin
                    r_acc[8*r_bcnt +: 8] <= s_byte;
                end
            end
            cc20_pkg::ST_CHECK: if (r_func != cc20_pkg::FUNC_UNIFORM) r_out <= r_acc;
            cc20_pkg::ST_MOD_RES: if (s_div_done) r_out <= s_rem;
            default: ;
        endcase
        if (r_st == cc20_pkg::ST_BLK_WAIT && s_bst.done) begin
            r_ks <= s_words;
        end
    end

    assign m_tvalid = r_mvalid;
    assign m_tdata  = r_out;

`ifndef NO_ASSERTIONS
    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= 7'd64) else $error("byte count out of range");
    a_ctr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == cc20_pkg::ST_BLK_WAIT && s_bst.done) |=> r_ctr == $past(r_ctr) + 64'd1)
        else $error("counter step");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready |-> r_st == cc20_pkg::ST_IDLE) else $error("ready while busy");
    a_blk_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_blk_start |-> !s_bst.busy) else $error("block start while busy");
`endif

endmodule

FILE: bench/tb.sv
// Testbench for the ChaCha20 random word generator: stream stimulus, APB key setup, predicted results.

class random_word_scoreboard;
    bit [63:0]   key_nonce[5];
    bit [63:0]   block_counter;
    bit [31:0]   keystream[16];
    int unsigned bytes_left;
    bit [31:0]   expected_values[$];
    int unsigned mismatches;
    int unsigned words_checked;

    function void reset_state();
        foreach (key_nonce[i]) key_nonce[i] = '0;
        block_counter = '0;
        bytes_left = 0;
    endfunction

    function void quarter(ref bit [31:0] x[16], input int a, int b, int c, int d);
        x[a] += x[b]; x[d] ^= x[a]; x[d] = {x[d][15:0], x[d][31:16]};
        x[c] += x[d]; x[b] ^= x[c]; x[b] = {x[b][19:0], x[b][31:20]};
        x[a] += x[b]; x[d] ^= x[a]; x[d] = {x[d][23:0], x[d][31:24]};
        x[c] += x[d]; x[b] ^= x[c]; x[b] = {x[b][24:0], x[b][31:25]};
    endfunction

    function void refill();
        bit [31:0] init[16];
        bit [31:0] x[16];
        init[0] = cc20_pkg::C_SIGMA0;
        init[1] = cc20_pkg::C_SIGMA1;
        init[2] = cc20_pkg::C_SIGMA2;
        init[3] = cc20_pkg::C_SIGMA3;
        for (int i = 0; i < 4; i++) begin
            init[4 + 2 * i] = key_nonce[i][31:0];
            init[5 + 2 * i] = key_nonce[i][63:32];
        end
        init[12] = block_counter[31:0];
        init[13] = block_counter[63:32];
        init[14] = key_nonce[cc20_pkg::REG_NONCE][31:0];
        init[15] = key_nonce[cc20_pkg::REG_NONCE][63:32];
        x = init;
        for (int r = 0; r < 10; r++) begin
            quarter(x, 0, 4, 8, 12); quarter(x, 1, 5, 9, 13);
            quarter(x, 2, 6, 10, 14); quarter(x, 3, 7, 11, 15);
            quarter(x, 0, 5, 10, 15); quarter(x, 1, 6, 11, 12);
            quarter(x, 2, 7, 8, 13); quarter(x, 3, 4, 9, 14);
        end
        for (int i = 0; i < 16; i++) keystream[i] = x[i] + init[i];
        bytes_left = 64;
        block_counter++;
    endfunction

    function bit [7:0] take_byte();
        int unsigned pos;
        if (bytes_left == 0) refill();
        pos = 64 - bytes_left;
        bytes_left--;
        return keystream[pos / 4][(pos % 4) * 8 +: 8];
    endfunction

    function bit [31:0] take_word();
        bit [31:0] w;
        for (int i = 0; i < 4; i++) w[8 * i +: 8] = take_byte();
        return w;
    endfunction

    function void note_request(cc20_pkg::t_func fn, bit [31:0] bound);
        bit [31:0] v;
        bit [31:0] thresh;
        bit [31:0] r;
        v = '0;
        case (fn)
            cc20_pkg::FUNC_WORD: v = take_word();
            cc20_pkg::FUNC_BYTE: v = {24'd0, take_byte()};
            cc20_pkg::FUNC_UNIFORM: begin
                if (bound >= 2) begin
                    thresh = (32'd0 - bound) % bound;
                    do r = take_word(); while (r < thresh);
                    v = r % bound;
                end
            end
            default: v = '0;
        endcase
        expected_values.push_back(v);
    endfunction

    task report(string what, bit [31:0] got, bit [31:0] want);
        mismatches++;
        $display("ERROR: %s got %h want %h", what, got, want);
    endtask

    task check_value(bit [31:0] got);
        bit [31:0] want;
        words_checked++;
        if (expected_values.size() == 0) begin
            report("unexpected word", got, '0);
            return;
        end
        want = expected_values.pop_front();
        if (got !== want) begin
            report("random_value", got, want);
        end
    endtask
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk, i_rst_n;
    logic        psel, penable, pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata, prdata;
    logic        pready;
    logic        s_tvalid, s_tready;
    logic [39:0] s_tdata;   // [1:0] func, [33:2] limit, [39:34] zero
    logic        m_tvalid, m_tready;
    logic [31:0] m_tdata;   // [31:0] random_value

    random_word_scoreboard sb;
    longint unsigned cycle_count;
    int unsigned     sent_words;
    bit              long_stall;
    bit              stall_done;
    int unsigned     uniform_count;

    chacha20_random_word_generator DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > 3_000_000) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) sb.check_value(m_tdata);
        if (i_rst_n && s_tvalid && s_tready)
            sb.note_request(cc20_pkg::t_func'(s_tdata[1:0]), s_tdata[33:2]);
    end

    // receiver: own stall pattern plus one long hold-off
    initial begin
        int unsigned mode;
        m_tready = 1'b0;
        stall_done = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_stall && !stall_done) begin
                m_tready = 1'b0;
                repeat (2000) @(negedge i_clk);
                stall_done = 1'b1;
            end
            mode = 32'((cycle_count / 500) % 3);
            if (mode == 0) m_tready = 1'b1;
            else if (mode == 1) m_tready = ($urandom_range(0, 3) != 0);
            else m_tready = ($urandom_range(0, 3) == 0);
        end
    end

    task automatic apb_write(input logic [2:0] idx, input logic [63:0] value);
        @(negedge i_clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = {idx, 3'b000}; pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        sb.key_nonce[idx] = value;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic send_request(input cc20_pkg::t_func fn, input logic [31:0] bound);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, bound, fn};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
        sent_words++;
        if (fn == cc20_pkg::FUNC_UNIFORM) uniform_count++;
    endtask

    task automatic go_idle();
        s_tvalid <= 1'b0;
        s_tdata  <= {8'($urandom), $urandom};
    endtask

    task automatic drain();
        go_idle();
        while (sb.expected_values.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_bound();
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 1);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            2: return 32'h8000_0000 + $urandom_range(0, 5);
            3: return $urandom_range(2, 20);
            4: return 32'd1 << $urandom_range(1, 31);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(input int unsigned n);
        int unsigned burst;
        int unsigned sel;
        cc20_pkg::t_func fn;
        while (n > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && n > 0) begin
                sel = $urandom_range(0, 9);
                fn = sel < 4 ? cc20_pkg::FUNC_WORD : sel < 7 ? cc20_pkg::FUNC_UNIFORM :
                     sel < 9 ? cc20_pkg::FUNC_BYTE : cc20_pkg::FUNC_NONE;
                send_request(fn, pick_bound());
                burst--; n--;
            end
            go_idle();
            if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 20)) @(negedge i_clk);
        end
        go_idle();
    endtask

    initial begin
        sb = new();
        sb.mismatches = 0;
        sb.words_checked = 0;
        sb.reset_state();
        sent_words = 0;
        uniform_count = 0;
        long_stall = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_tvalid = 1'b0; s_tdata = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // all-zero key: known ChaCha20 block, then edges of the func and limit fields
        send_request(cc20_pkg::FUNC_WORD, 32'd0);
        send_request(cc20_pkg::FUNC_BYTE, 32'hFFFF_FFFF);
        send_request(cc20_pkg::FUNC_BYTE, 32'd0);
        send_request(cc20_pkg::FUNC_BYTE, 32'd0);
        send_request(cc20_pkg::FUNC_WORD, 32'd0);
        send_request(cc20_pkg::FUNC_NONE, 32'hFFFF_FFFF);
        send_request(cc20_pkg::FUNC_UNIFORM, 32'd0);
        send_request(cc20_pkg::FUNC_UNIFORM, 32'd1);
        send_request(cc20_pkg::FUNC_UNIFORM, 32'd2);
        send_request(cc20_pkg::FUNC_UNIFORM, 32'd3);
        send_request(cc20_pkg::FUNC_UNIFORM, 32'hFFFF_FFFF);
        send_request(cc20_pkg::FUNC_UNIFORM, 32'h8000_0001);
        send_request(cc20_pkg::FUNC_UNIFORM, 32'h5555_5555);
        for (int i = 0; i < 12; i++) send_request(cc20_pkg::FUNC_WORD, 32'hAAAA_AAAA);
        drain();

        apb_write(cc20_pkg::REG_KEY01, 64'hFFFF_FFFF_FFFF_FFFF);
        apb_write(cc20_pkg::REG_KEY23, 64'hFFFF_FFFF_FFFF_FFFF);
        apb_write(cc20_pkg::REG_KEY45, 64'hFFFF_FFFF_FFFF_FFFF);
        apb_write(cc20_pkg::REG_KEY67, 64'hFFFF_FFFF_FFFF_FFFF);
        apb_write(cc20_pkg::REG_NONCE, 64'hFFFF_FFFF_FFFF_FFFF);
        random_phase(300);

        // hold the output off while requests keep coming
        long_stall = 1'b1;
        random_phase(100);
        drain();

        for (int p = 0; p < 3; p++) begin
            for (int r = 0; r < 5; r++) apb_write(r[2:0], {$urandom, $urandom});
            random_phase(280);
            drain();
        end
        for (int r = 0; r < 5; r++) apb_write(r[2:0], 64'd0);
        random_phase(50);
        drain();

        $display("%0d requests sent (%0d uniform), %0d words checked, %0d blocks used",
                 sent_words, uniform_count, sb.words_checked, sb.block_counter);
        if (sb.mismatches == 0 && sb.expected_values.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d words missing",
                     sb.mismatches, sb.expected_values.size());
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

FILE: chacha20_random_word_generator.f
hw/rtl/cc20_pkg.sv
hw/rtl/cc20_core.sv
hw/rtl/cc20_divu.sv
hw/rtl/chacha20_random_word_generator.sv
bench/tb.sv
